FILE: rtl/core/bf16_scale_by_f32_factor_core_defines.svh
// Assertion macros for the bf16 scaling core.
// Included by the RTL files that carry concurrent checks.
`ifndef BF16_SCALE_BY_F32_FACTOR_CORE_DEFINES_SVH
`define BF16_SCALE_BY_F32_FACTOR_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BSF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication, checked outside reset.
`define BSF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

FILE: rtl/core/bsf_pkg.sv
// Types, constants and helpers for the bf16 scaling core.
// Self-contained; used by bf16_scale_by_f32_factor_core.
`timescale 1ns / 1ps

package bsf_pkg;

  localparam logic [31:0] ONE_BITS    = 32'h3F80_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] POS_INF     = 32'h7F80_0000;
  localparam logic [7:0]  EXP_MAX     = 8'hFF;
  localparam logic [15:0] NARROW_BIAS = 16'h7FFF;

  // Unpacked factor, kept beside the raw register.
  typedef struct packed {
    logic               nan;
    logic               expmax;
    logic               zero;
    logic signed [10:0] exp;
    logic [23:0]        mant;
  } factor_t;

  // Left shift that brings the top set bit of a subnormal fraction to bit 23.
  function automatic logic [4:0] norm_shift(input logic [22:0] frac);
    logic [4:0] k;
    k = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (frac[i]) k = 5'(23 - i);
    end
    return k;
  endfunction

  function automatic factor_t unpack_factor(input logic [31:0] b);
    factor_t    f;
    logic [4:0] k;
    k        = norm_shift(b[22:0]);
    f.nan    = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
    f.expmax = (b[30:23] == EXP_MAX);
    f.zero   = (b[30:0] == 31'd0);
    if (b[30:23] == 8'd0) begin
      f.exp  = 11'sd1 - 11'(k);
      f.mant = {1'b0, b[22:0]} << k;
    end else begin
      f.exp  = 11'({3'd0, b[30:23]});
      f.mant = {1'b1, b[22:0]};
    end
    return f;
  endfunction

endpackage

FILE: rtl/core/bf16_scale_by_f32_factor_core.sv
// Top level of the bf16 scaling core: bf16 weight times binary32 factor.
// Depends on bsf_pkg and bf16_scale_by_f32_factor_core_defines.svh.
//
//   channel | signals                           | direction
//   input   | in_valid, in_stall, weight_in     | item in
//   output  | out_valid, out_stall, weight_out  | item out
//   config  | cfg_valid, cfg_ready, scale_factor| register write
//
// One item per cycle while the output is not stalled; each item passes the input
// register, the product register and the result register. The 8x24 significand
// multiplier sets the first stage, the rounding shifter the second.
// Reset (rst, synchronous) empties all stages and sets the factor to 1.0.
// A stall on the output holds the result; each stage still fills behind it.
`timescale 1ns / 1ps
`include "bf16_scale_by_f32_factor_core_defines.svh"

module bf16_scale_by_f32_factor_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] weight_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] weight_out,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] scale_factor
);

  logic [31:0]       factor;
  bsf_pkg::factor_t  fu;

  logic        a_valid;
  logic [15:0] a_w;

  logic               b_valid;
  logic               b_special;
  logic               b_bypass;
  logic [31:0]        b_val;
  logic               b_sign;
  logic signed [10:0] b_exp;
  logic [31:0]        b_q;

  logic o_free, b_free, a_free;

  assign cfg_ready = 1'b1;
  assign o_free    = !out_valid || !out_stall;
  assign b_free    = !b_valid || o_free;
  assign a_free    = !a_valid || b_free;
  assign in_stall  = !a_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      factor <= bsf_pkg::ONE_BITS;
      fu     <= bsf_pkg::unpack_factor(bsf_pkg::ONE_BITS);
    end else if (cfg_valid && cfg_ready) begin
      factor <= scale_factor;
      fu     <= bsf_pkg::unpack_factor(scale_factor);
    end
  end

  // Stage A: input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_free) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_free && in_valid) a_w <= weight_in;
  end

  // Stage A logic: specials, unpack, significand product.
  logic [31:0]        wa;
  logic               a_nan, a_expmax, a_zero, sign_c;
  logic [4:0]         ka;
  logic [23:0]        ma24;
  logic signed [10:0] ea;
  logic               special_c;
  logic [31:0]        special_val;

  always_comb begin
    wa       = {a_w, 16'd0};
    a_expmax = (wa[30:23] == bsf_pkg::EXP_MAX);
    a_nan    = a_expmax && (wa[22:0] != 23'd0);
    a_zero   = (wa[30:0] == 31'd0);
    sign_c   = wa[31] ^ factor[31];
    ka       = bsf_pkg::norm_shift(wa[22:0]);
    if (wa[30:23] == 8'd0) begin
      ea   = 11'sd1 - 11'(ka);
      ma24 = {1'b0, wa[22:0]} << ka;
    end else begin
      ea   = 11'({3'd0, wa[30:23]});
      ma24 = {1'b1, wa[22:0]};
    end
    special_c   = 1'b1;
    special_val = {sign_c, 31'd0};
    priority if (a_nan) begin
      special_val = wa | bsf_pkg::QUIET_BIT;
    end else if (fu.nan) begin
      special_val = factor | bsf_pkg::QUIET_BIT;
    end else if (a_expmax || fu.expmax) begin
      special_val = (a_zero || fu.zero) ? bsf_pkg::DEFAULT_NAN
                                        : ({sign_c, 31'd0} | bsf_pkg::POS_INF);
    end else if (a_zero || fu.zero) begin
      special_val = {sign_c, 31'd0};
    end else begin
      special_c = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_free && a_valid) begin
      b_bypass  <= (factor == bsf_pkg::ONE_BITS);
      b_special <= special_c;
      b_val     <= (factor == bsf_pkg::ONE_BITS) ? wa : special_val;
      b_sign    <= sign_c;
      b_exp     <= ea + fu.exp - 11'sd127;
      b_q       <= ma24[23:16] * fu.mant;
    end
  end

  // Stage B logic: normalize, round, narrow.
  logic signed [10:0] e1, e2;
  logic [31:0]        qn;
  logic [63:0]        p, mask;
  logic [5:0]         sh;
  logic [24:0]        m;
  logic               rbit, sticky;
  logic [31:0]        prod, fin;
  logic [31:0]        nsum;

  always_comb begin
    e1   = b_exp + 11'(b_q[31]);
    qn   = b_q[31] ? b_q : (b_q << 1);
    p    = {16'd0, qn, 16'd0};
    sh   = 6'd24;
    if (e1 < 11'sd1) begin
      sh = (e1 < -11'sd25) ? 6'd50 : 6'(11'sd25 - e1);
    end
    m      = 25'(p >> sh);
    rbit   = p[sh - 6'd1];
    mask   = (64'd1 << (sh - 6'd1)) - 64'd1;
    sticky = (p & mask) != 64'd0;
    if (rbit && (sticky || m[0])) m = m + 25'd1;
    e2 = e1;
    if (e1 >= 11'sd255) begin
      prod = {b_sign, 31'd0} | bsf_pkg::POS_INF;
    end else if (e1 < 11'sd1) begin
      prod = {b_sign, 31'd0} | {7'd0, m};
    end else begin
      if (m[24]) begin
        m  = m >> 1;
        e2 = e1 + 11'sd1;
      end
      if (e2 >= 11'sd255) prod = {b_sign, 31'd0} | bsf_pkg::POS_INF;
      else prod = {b_sign, e2[7:0], m[22:0]};
    end
    fin  = b_special ? b_val : prod;
    nsum = fin + {16'd0, bsf_pkg::NARROW_BIAS} + {31'd0, fin[16]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_free) begin
      out_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_free && b_valid) weight_out <= b_bypass ? b_val[31:16] : nsum[31:16];
  end

  `BSF_ASSERT_NOW(a_stall_full, clk, rst, in_stall, a_valid && b_valid && out_valid)
  `BSF_ASSERT_NEXT(a_mid_hold, clk, rst, b_valid && !o_free, b_valid)
  `BSF_ASSERT_NEXT(a_no_invent, clk, rst, out_valid && !out_stall && !b_valid, !out_valid)

endmodule

FILE: tb/tb_bf16_scale_by_f32_factor_core.sv
// Testbench for bf16_scale_by_f32_factor_core: streams bf16 weights through the
// scaler under several factor settings and checks each result against a local
// binary32 multiply and bf16 narrowing predictor. Depends on the core RTL only.
`timescale 1ns / 1ps

module tb_bf16_scale_by_f32_factor_core;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] weight_in;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] weight_out;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] scale_factor;

  localparam logic [31:0] FACTOR_ONE  = 32'h3F80_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'hFFC0_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;

  logic [31:0] factor_q;
  logic [15:0] scaled_q[$];
  int          errors;
  int          sent;
  int          checked;
  int          send_idle_pct;
  int          recv_stall_pct;
  bit          hold_recv;
  int          hold_cycles;

  bf16_scale_by_f32_factor_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .weight_in(weight_in),
    .out_valid(out_valid), .out_stall(out_stall), .weight_out(weight_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .scale_factor(scale_factor)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic bit f32_is_nan(logic [31:0] x);
    return x[30:23] == 8'hFF && x[22:0] != 23'd0;
  endfunction

  // Normalize a finite nonzero value to a 24-bit significand with bit 23 set.
  function automatic void f32_unpack(input logic [31:0] x, output int e,
                                     output logic [23:0] m);
    e = x[30:23];
    m = {1'b0, x[22:0]};
    if (e == 0) begin
      e = 1;
      while (!m[23]) begin
        m = m << 1;
        e--;
      end
    end else begin
      m[23] = 1'b1;
    end
  endfunction

  function automatic logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
    logic [31:0] sgn;
    logic [23:0] ma;
    logic [23:0] mb;
    logic [63:0] p;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] m;
    int          ea;
    int          eb;
    int          e;
    int          sh;
    sgn = (a ^ b) & 32'h8000_0000;
    if (f32_is_nan(a)) return a | QUIET_BIT;
    if (f32_is_nan(b)) return b | QUIET_BIT;
    if (a[30:23] == 8'hFF || b[30:23] == 8'hFF) begin
      if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return DEFAULT_NAN;
      return sgn | 32'h7F80_0000;
    end
    if (a[30:0] == 31'd0 || b[30:0] == 31'd0) return sgn;
    f32_unpack(a, ea, ma);
    f32_unpack(b, eb, mb);
    p = 64'(ma) * 64'(mb);
    e = ea + eb - 127;
    if (p[47]) e++;
    else p = p << 1;
    if (e >= 255) return sgn | 32'h7F80_0000;
    sh = 24;
    if (e < 1) sh += (1 - e > 26) ? 26 : 1 - e;
    m = 32'(p >> sh);
    rem = p & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && m[0])) m++;
    if (e < 1) return sgn | m;
    if (m == 32'h0100_0000) begin
      m = m >> 1;
      e++;
      if (e >= 255) return sgn | 32'h7F80_0000;
    end
    return sgn | (32'(e) << 23) | (m & 32'h007F_FFFF);
  endfunction

  function automatic logic [15:0] scaled_weight(logic [15:0] w, logic [31:0] f);
    logic [31:0] prod;
    if (f == FACTOR_ONE) return w;
    prod = f32_mul({w, 16'h0000}, f);
    prod = prod + 32'h7FFF + 32'(prod[16]);
    return prod[31:16];
  endfunction

  // Receiver stall: random by percentage, or forced high during a hold-off.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
  end

  // Long hold-off counted in cycles in its own process.
  initial begin
    hold_recv = 1'b0;
    wait (hold_cycles > 0);
    @(posedge clk);
    hold_recv = 1'b1;
    repeat (hold_cycles) @(posedge clk);
    hold_recv = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (scaled_q.size() == 0) begin
        $display("%0t: unexpected item weight_out=%h", $time, weight_out);
        errors++;
      end else begin
        if (weight_out !== scaled_q[0]) begin
          $display("%0t: weight_out expected %h actual %h", $time, scaled_q[0], weight_out);
          errors++;
        end
        void'(scaled_q.pop_front());
        checked++;
      end
    end
  end

  // Leaves in_valid high after the accepting edge; drain lowers it, and the next send keeps it high unless it idles.
  task automatic send_weight(logic [15:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    weight_in <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    scaled_q.insert(scaled_q.size(), scaled_weight(w, factor_q));
    sent++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (scaled_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_factor(logic [31:0] f);
    drain();
    cfg_valid <= 1'b1;
    scale_factor <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    factor_q = f;
    @(posedge clk);
  endtask

  function automatic logic [15:0] random_weight();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 8'hFF, 7'($urandom)};
      1: return {1'($urandom_range(1)), 8'h00, 7'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] random_factor();
    case ($urandom_range(5))
      0: return {1'($urandom_range(1)), 8'h00, 23'($urandom)};
      1: return {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
      2: return {1'($urandom_range(1)), 8'($urandom_range(100, 150)), 23'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  task automatic test_bypass_reset();
    logic [15:0] w[8] = '{16'h0000, 16'h8000, 16'hFFFF, 16'h7FC1,
                          16'h7F80, 16'hFF80, 16'h0001, 16'h3F80};
    foreach (w[i]) send_weight(w[i]);
  endtask

  task automatic test_directed();
    logic [31:0] f[8] = '{32'hBF80_0000, 32'h8000_0000, 32'h0000_0000, 32'h7F80_0000,
                          32'h7FA0_0001, 32'h0000_0001, 32'h7F7F_FFFF, 32'hFFFF_FFFF};
    logic [15:0] w[6] = '{16'h0000, 16'hFF80, 16'h7F81, 16'h0001, 16'h7F7F, 16'hBF80};
    foreach (f[i]) begin
      write_factor(f[i]);
      foreach (w[j]) send_weight(w[j]);
    end
    write_factor(32'h3F80_0001);
    send_weight(16'h7FFF);
    send_weight(16'h3F81);
  endtask

  task automatic test_random(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if (i % 50 == 0) write_factor(random_factor());
      send_weight(random_weight());
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    write_factor(32'h4049_0FDB);
    hold_cycles = 40;
    repeat (30) send_weight(random_weight());
    drain();
    // Pause until every result has come, then resume.
    repeat (10) send_weight(random_weight());
  endtask

  initial begin
    #2_000_000;
    $display("tb_bf16_scale_by_f32_factor_core failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    weight_in = '0;
    cfg_valid = 1'b0;
    scale_factor = FACTOR_ONE;
    factor_q = FACTOR_ONE;
    errors = 0;
    sent = 0;
    checked = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_bypass_reset();
    test_directed();
    test_random(200, 0, 0);
    test_random(200, 47, 0);
    test_random(200, 0, 47);
    test_random(200, 15, 15);
    test_backpressure();
    write_factor(FACTOR_ONE);
    repeat (10) send_weight(random_weight());
    drain();
    $display("Sent %0d weights, checked %0d results across bypass, special values,",
             sent, checked);
    $display("random factors and idle/stall phases including a long output hold-off.");
    if (errors == 0) begin
      $display("tb_bf16_scale_by_f32_factor_core passed");
    end else begin
      $display("tb_bf16_scale_by_f32_factor_core failed");
    end
    $finish;
  end

endmodule
